FILE: sv/cmwc_pkg.sv
// shared constants and types of the lag-1024 cmwc generator
// no dependencies; used by cmwc_lag1024_generator
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

	// lag table geometry
	localparam int unsigned LAG_DEPTH = 1024;
	localparam int unsigned POS_W     = $clog2(LAG_DEPTH);

	// word and multiplier geometry
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned MULT_W    = 17;
	localparam int unsigned Z_W       = WORD_W + MULT_W;
	localparam logic [MULT_W-1:0] CMWC_MULT = MULT_W'(109111);

	// item field widths
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned INDEX_W   = 10;
	localparam int unsigned IN_DATA_W  = 48; // index + value, padded to whole bytes
	localparam int unsigned OUT_DATA_W = 64; // number + carry_now

	typedef enum logic [KIND_W-1:0] {
		KIND_GEN   = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CARRY = 2'd3
	} kind_t;

endpackage

`default_nettype wire

FILE: sv/cmwc_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// read returns the old word on a same-cycle write to the same address; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cmwc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/cmwc_lag1024_generator.sv
// top level of the lag-1024 complementary multiply-with-carry generator
// depends on cmwc_pkg and cmwc_ram
// a result item leaves on m_tvalid from the stage 2 result register, behind stage 1
// throughput: one item per cycle unless a full result register waits on m_tready; the carry
//   loop closes through one 32x17 multiply-add in stage 1; the lag word is read in stage 0
// reset: arst_n clears carry, position and the pipeline at once; the lag table has no reset
`timescale 1ns / 1ps
`default_nettype none

module cmwc_lag1024_generator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input items
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [cmwc_pkg::IN_DATA_W-1:0]   s_tdata,  // index[9:0], value[41:10], zero pad
	input  wire logic [cmwc_pkg::KIND_W-1:0]      s_tuser,  // kind[1:0]
	// result items
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [cmwc_pkg::OUT_DATA_W-1:0]  m_tdata   // number[31:0], carry_now[63:32]
);

	localparam int unsigned AW = cmwc_pkg::POS_W;
	localparam int unsigned WW = cmwc_pkg::WORD_W;
	localparam int unsigned ZW = cmwc_pkg::Z_W;

	// ---------------------------------------------------------------
	// stage 0: unpack the accepted item and issue the lag read
	// ---------------------------------------------------------------
	cmwc_pkg::kind_t                    in_kind;
	logic [cmwc_pkg::INDEX_W-1:0]       in_index;
	logic [WW-1:0]                      in_value;
	logic                               in_range;
	logic [AW-1:0]                      rd_addr;
	logic                               accept;
	logic                               adv;

	assign in_kind  = cmwc_pkg::kind_t'(s_tuser);
	assign in_index = s_tdata[cmwc_pkg::INDEX_W-1:0];
	assign in_value = s_tdata[cmwc_pkg::INDEX_W +: WW];
	// only matters when the table is smaller than the index field can address
	assign in_range = 32'(in_index) < cmwc_pkg::LAG_DEPTH;

	// position pointer, advanced as each generate item enters
	logic [AW-1:0] pos_q;
	logic [AW-1:0] pos_next;

	assign pos_next = (pos_q == AW'(cmwc_pkg::LAG_DEPTH - 1)) ? '0 : pos_q + AW'(1);

	// generate items read the lag word at the position, reads at the index
	assign rd_addr = (in_kind == cmwc_pkg::KIND_GEN) ? pos_q : AW'(in_index);

	// ---------------------------------------------------------------
	// stage 1 registers
	// ---------------------------------------------------------------
	logic                valid_s1;
	cmwc_pkg::kind_t     kind_s1;
	logic [AW-1:0]       addr_s1;
	logic                in_range_s1;
	logic [WW-1:0]       value_s1;
	logic                byp_hit_s1;
	logic [WW-1:0]       byp_data_s1;

	// result register (stage 2)
	logic                out_valid_s2;
	logic [WW-1:0]       number_s2;
	logic [WW-1:0]       carry_s2;

	logic [WW-1:0]       carry_q;

	// stage 1 holds only when it has a result and the output register is still full
	logic res_s1;
	assign res_s1 = (kind_s1 == cmwc_pkg::KIND_GEN) || (kind_s1 == cmwc_pkg::KIND_READ);
	assign adv    = !valid_s1 || !res_s1 || !out_valid_s2 || m_tready;

	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	// ---------------------------------------------------------------
	// lag table memory
	// ---------------------------------------------------------------
	logic          ram_we;
	logic [WW-1:0] ram_wdata;
	logic [WW-1:0] ram_rdata;

	cmwc_ram #(
		.WIDTH (WW),
		.DEPTH (cmwc_pkg::LAG_DEPTH)
	) u_lag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.re    (adv),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// stage 1: multiply-add and write back
	// ---------------------------------------------------------------
	logic [WW-1:0] lag_word;
	logic [ZW-1:0] z;
	logic [WW-1:0] gen_number;
	logic [WW-1:0] gen_carry;

	// the ram returns the old word when stage 1 wrote the same entry as it was read
	assign lag_word   = byp_hit_s1 ? byp_data_s1 : ram_rdata;
	assign z          = ZW'(cmwc_pkg::CMWC_MULT) * ZW'(lag_word) + ZW'(carry_q);
	assign gen_number = ~z[WW-1:0];
	assign gen_carry  = WW'(z[ZW-1:WW]);

	// all table writes, generate or load, happen here and only when the stage moves on
	assign ram_we = valid_s1 && adv &&
		((kind_s1 == cmwc_pkg::KIND_GEN) || ((kind_s1 == cmwc_pkg::KIND_WRITE) && in_range_s1));
	assign ram_wdata = (kind_s1 == cmwc_pkg::KIND_GEN) ? gen_number : value_s1;

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			byp_hit_s1   <= 1'b0;
			out_valid_s2 <= 1'b0;
			pos_q        <= '0;
			carry_q      <= '0;
		end else begin
			if (adv) begin
				valid_s1   <= s_tvalid;
				byp_hit_s1 <= ram_we && (addr_s1 == rd_addr);
				if (accept && (in_kind == cmwc_pkg::KIND_GEN)) begin
					pos_q <= pos_next;
				end
				if (valid_s1) begin
					case (kind_s1)
						cmwc_pkg::KIND_GEN:   carry_q <= gen_carry;
						cmwc_pkg::KIND_CARRY: carry_q <= value_s1;
						default:              carry_q <= carry_q;
					endcase
				end
			end
			if (adv && valid_s1 && res_s1) begin
				out_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1     <= in_kind;
			addr_s1     <= rd_addr;
			in_range_s1 <= in_range;
			value_s1    <= in_value;
			byp_data_s1 <= ram_wdata;
			if (valid_s1 && res_s1) begin
				if (kind_s1 == cmwc_pkg::KIND_GEN) begin
					number_s2 <= gen_number;
					carry_s2  <= gen_carry;
				end else begin
					number_s2 <= in_range_s1 ? lag_word : '0;
					carry_s2  <= carry_q;
				end
			end
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {carry_s2, number_s2};

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_pos_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_kind == cmwc_pkg::KIND_GEN)) |=> (pos_q != $past(pos_q)))
		else $error("position did not advance on a generate item");

	a_pos_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!(accept && (in_kind == cmwc_pkg::KIND_GEN))) |=> (pos_q == $past(pos_q)))
		else $error("position moved without a generate item");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && res_s1 && adv))
		else $error("result appeared without a result item in stage 1");

	a_bypass_src: assert property (@(posedge clk) disable iff (!arst_n)
		byp_hit_s1 |-> ($past(ram_we) || $stable(byp_data_s1)))
		else $error("bypass hit without a preceding table write");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(addr_s1) && !ram_we || adv))
		else $error("stalled stage 1 item lost");

endmodule

`default_nettype wire

FILE: bench/tb_cmwc_lag1024_generator.sv
// self-checking bench for cmwc_lag1024_generator: a table fill, directed rows, then random items
// scored against an in-bench copy of the lag table, carry and position
// depends on cmwc_pkg and the generator rtl
`timescale 1ns / 1ps

module tb_cmwc_lag1024_generator;
	import cmwc_pkg::*;

	// idle cycles with no item moving on either side before the run is called dead
	localparam int QUIET_LIMIT = 2000;
	// receiver hold-off that backs the pipeline up into the input
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 200;
	// low lag entries written up front; generates and reads stay among the written ones
	localparam int FILL_WORDS = 192;

	typedef struct packed {
		logic [WORD_W-1:0] number;
		logic [WORD_W-1:0] carry_now;
	} number_pair_t;

	typedef struct {
		kind_t              kind;
		logic [INDEX_W-1:0] index;
		logic [WORD_W-1:0]  value;
		bit                 typed;
		logic [WORD_W-1:0]  exp_number;
		logic [WORD_W-1:0]  exp_carry;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;   // index[9:0], value[41:10], zero pad
	logic [KIND_W-1:0] s_tuser;      // kind[1:0]
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // number[31:0], carry_now[63:32]

	// mirror of the generator state
	logic [WORD_W-1:0] lag_mirror [LAG_DEPTH];
	logic [WORD_W-1:0] carry_mirror;
	logic [POS_W-1:0]  pos_mirror;

	number_pair_t due_numbers [$];
	int  mismatches;
	int  quiet_cycles;
	bit  calm;       // both sides stop idling
	bit  hold_req;   // sender asks the receiver for the long hold-off
	bit  holding;

	// positions 0..2 and 1023 are preloaded with extremes by the fill pass;
	// carry is zero after reset
	directed_row_t directed_rows [0:22] = '{
		'{KIND_READ,  10'd0,    32'h0,        1'b1, 32'h0,        32'h0},
		'{KIND_READ,  10'd1023, 32'h0,        1'b1, 32'hFFFFFFFF, 32'h0},
		// zero lag word, zero carry
		'{KIND_GEN,   10'd0,    32'h0,        1'b1, 32'hFFFFFFFF, 32'h0},
		'{KIND_CARRY, 10'd0,    32'hFFFFFFFF, 1'b0, 32'h0,        32'h0},
		// all-ones lag word and carry: largest z, high word still fits
		'{KIND_GEN,   10'd0,    32'h0,        1'b1, 32'h0001AA37, 32'h0001AA37},
		'{KIND_READ,  10'd0,    32'h0,        1'b1, 32'hFFFFFFFF, 32'h0001AA37},
		'{KIND_READ,  10'd1,    32'h0,        1'b1, 32'h0001AA37, 32'h0001AA37},
		'{KIND_CARRY, 10'd1023, 32'h0,        1'b0, 32'h0,        32'h0},
		'{KIND_GEN,   10'd0,    32'h0,        1'b1, 32'h0001AA36, 32'h0001AA36},
		'{KIND_WRITE, 10'd1023, 32'h0,        1'b0, 32'h0,        32'h0},
		'{KIND_READ,  10'd1023, 32'h0,        1'b1, 32'h0,        32'h0001AA36},
		'{KIND_WRITE, 10'd5,    32'hA5A5A5A5, 1'b0, 32'h0,        32'h0},
		'{KIND_READ,  10'd5,    32'h0,        1'b1, 32'hA5A5A5A5, 32'h0001AA36},
		'{KIND_CARRY, 10'd0,    32'h12345678, 1'b0, 32'h0,        32'h0},
		'{KIND_GEN,   10'd0,    32'h0,        1'b0, 32'h0,        32'h0},
		'{KIND_GEN,   10'd0,    32'h0,        1'b0, 32'h0,        32'h0},
		'{KIND_READ,  10'd3,    32'h0,        1'b0, 32'h0,        32'h0},
		'{KIND_WRITE, 10'd512,  32'h5A5A5A5A, 1'b0, 32'h0,        32'h0},
		'{KIND_READ,  10'd512,  32'h0,        1'b0, 32'h0,        32'h0},
		'{KIND_CARRY, 10'd0,    32'hFFFFFFFF, 1'b0, 32'h0,        32'h0},
		'{KIND_GEN,   10'd0,    32'h0,        1'b0, 32'h0,        32'h0},
		// index and value fields that the kind does not use carry junk
		'{KIND_READ,  10'd1023, 32'hFFFFFFFF, 1'b0, 32'h0,        32'h0},
		'{KIND_GEN,   10'd1023, 32'hFFFFFFFF, 1'b0, 32'h0,        32'h0}
	};

	cmwc_lag1024_generator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// one accepted item applied to the mirrored state; generate and read give a result
	task automatic advance_generator(input kind_t kind, input logic [INDEX_W-1:0] index,
			input logic [WORD_W-1:0] value, output bit has_result, output number_pair_t res);
		logic [Z_W-1:0] z;
		has_result = 1'b0;
		res = '0;
		case (kind)
			KIND_GEN: begin
				z = Z_W'(CMWC_MULT) * Z_W'(lag_mirror[pos_mirror]) + Z_W'(carry_mirror);
				lag_mirror[pos_mirror] = ~z[WORD_W-1:0];
				carry_mirror = WORD_W'(z[Z_W-1:WORD_W]);
				res.number = lag_mirror[pos_mirror];
				res.carry_now = carry_mirror;
				has_result = 1'b1;
				// wrap back to entry zero after the last lag word
				if (pos_mirror == POS_W'(LAG_DEPTH - 1)) begin
					pos_mirror = '0;
				end else begin
					pos_mirror = pos_mirror + POS_W'(1);
				end
			end
			KIND_WRITE: lag_mirror[index] = value;
			KIND_READ: begin
				res.number = lag_mirror[index];
				res.carry_now = carry_mirror;
				has_result = 1'b1;
			end
			default: carry_mirror = value;
		endcase
	endtask

	// offers one item, waits for it to be taken, then queues what it should produce
	task automatic offer_item(input kind_t kind, input logic [INDEX_W-1:0] index,
			input logic [WORD_W-1:0] value, input bit typed, input number_pair_t typed_res);
		bit has_result;
		number_pair_t res;
		@(negedge clk);
		if (!calm && !holding && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_DATA_W - WORD_W - INDEX_W){1'b0}}, value, index};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_generator(kind, index, value, has_result, res);
		if (has_result) due_numbers.push_back(typed ? typed_res : res);
	endtask

	// mostly random words, with the all-zero and all-one extremes mixed in
	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 10) return '1;
		return $urandom;
	endfunction

	// result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin
		number_pair_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_numbers.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual number %h carry %h",
					$time, m_tdata[WORD_W-1:0], m_tdata[OUT_DATA_W-1:WORD_W]);
				mismatches++;
			end else begin
				want = due_numbers.pop_front();
				if (m_tdata[WORD_W-1:0] !== want.number) begin
					$display("%0t: number mismatch, expected %h, actual %h",
						$time, want.number, m_tdata[WORD_W-1:0]);
					mismatches++;
				end
				if (m_tdata[OUT_DATA_W-1:WORD_W] !== want.carry_now) begin
					$display("%0t: carry_now mismatch, expected %h, actual %h",
						$time, want.carry_now, m_tdata[OUT_DATA_W-1:WORD_W]);
					mismatches++;
				end
			end
		end
	end

	// receiver: random stalls, a calm stretch, and one long hold-off on request
	initial begin
		m_tready = 1'b0;
		holding = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !holding) begin
				holding = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				holding = 1'b0;
				m_tready <= 1'b1;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 35);
			end
		end
	end

	// watchdog on cycles in which no item moves
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		int r;
		int rnd_items;
		kind_t kind;
		logic [WORD_W-1:0] word;
		logic [INDEX_W-1:0] index;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_GEN;
		calm = 1'b0;
		hold_req = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		carry_mirror = '0;
		pos_mirror = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// the low entries and the last one are written before anything is generated or read
		for (int i = 0; i < FILL_WORDS; i++) begin
			if (i == 0) word = '0;
			else if (i == 1 || i == 2) word = '1;
			else word = $urandom;
			offer_item(KIND_WRITE, INDEX_W'(i), word, 1'b0, '0);
		end
		offer_item(KIND_WRITE, INDEX_W'(LAG_DEPTH - 1), '1, 1'b0, '0);

		foreach (directed_rows[i])
			offer_item(directed_rows[i].kind, directed_rows[i].index, directed_rows[i].value,
				directed_rows[i].typed, {directed_rows[i].exp_number, directed_rows[i].exp_carry});

		// random part: generates and reads only touch written entries, writes go anywhere
		rnd_items = 0;
		while (rnd_items < RANDOM_ITEMS) begin
			if (rnd_items == 60) hold_req = 1'b1;
			calm = (rnd_items >= 100 && rnd_items < 170);
			r = $urandom_range(99);
			if (r < 50) kind = KIND_GEN;
			else if (r < 70) kind = KIND_READ;
			else if (r < 88) kind = KIND_WRITE;
			else kind = KIND_CARRY;
			// generates stop before the position leaves the written entries
			if (kind == KIND_GEN && int'(pos_mirror) >= FILL_WORDS) kind = KIND_READ;
			if (kind == KIND_READ) begin
				if ($urandom_range(9) == 0) index = INDEX_W'(LAG_DEPTH - 1);
				else index = INDEX_W'($urandom_range(FILL_WORDS - 1));
			end else begin
				index = INDEX_W'($urandom_range(LAG_DEPTH - 1));
			end
			offer_item(kind, index, pick_word(), 1'b0, '0);
			rnd_items++;
		end
		calm = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain, then give the pipeline time to show any stray result
		while (due_numbers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
